### hdl/dpot_pkg.sv
package dpot_pkg;

  localparam int unsigned ADDR_W  = 64;
  localparam int unsigned LEN_W   = 32;
  localparam int unsigned PAGE_SH = 12;
  localparam int unsigned FRAME_W = ADDR_W - PAGE_SH;
  localparam logic [ADDR_W-1:0] PAGE_MASK = 64'h0000_0000_0000_0FFF;

  typedef enum logic [1:0] {
    REQ_GRANT  = 2'd0,
    REQ_CHECK  = 2'd1,
    REQ_REVOKE = 2'd2,
    REQ_NONE   = 2'd3
  } req_t;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_DENY   = 2'd1,
    ST_BADSID = 2'd2,
    ST_FULL   = 2'd3
  } status_t;

  typedef struct packed {
    logic load;
    logic calc_sum;
    logic calc_hi;
    logic setup;
    logic set_use;
    logic clr_use;
    logic grant_step;
    logic cnt_wr;
    logic hit_step;
    logic miss_step;
  } cmd_t;

  typedef struct packed {
    logic   sid_bad;
    logic   in_use;
    logic   empty;
    logic   too_many;
    logic   grant_end;
    logic   full;
    logic   hit;
    logic   last_page;
    logic   last_entry;
    req_t   req;
  } sts_t;

endpackage

### hdl/dpot_ram.sv
module dpot_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

### hdl/dpot_dp.sv
module dpot_dp #(
  parameter int SESSIONS         = 8,
  parameter int PAGES_PER_DOMAIN = 1024
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic [1:0]                    in_req_type,
  input  logic [7:0]                    in_session,
  input  logic [dpot_pkg::ADDR_W-1:0]   in_address,
  input  logic [dpot_pkg::LEN_W-1:0]    in_length,
  input  dpot_pkg::cmd_t                cmd,
  output dpot_pkg::sts_t                sts
);

  localparam int SW    = (SESSIONS > 1) ? $clog2(SESSIONS) : 1;
  localparam int CW    = $clog2(PAGES_PER_DOMAIN + 1);
  localparam int DEPTH = SESSIONS * PAGES_PER_DOMAIN;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int FW    = dpot_pkg::FRAME_W;

  logic [1:0]                    req_r;
  logic [7:0]                    sess_r;
  logic [dpot_pkg::ADDR_W-1:0]   addr_r;
  logic [dpot_pkg::LEN_W-1:0]    len_r;
  logic [dpot_pkg::ADDR_W-1:0]   sum_r;
  logic [FW-1:0]                 hi_r;
  logic [FW-1:0]                 p_r;
  logic [CW-1:0]                 cnt_r;
  logic [CW-1:0]                 idx_r;
  logic [CW-1:0]                 rem_r;
  logic [AW-1:0]                 base_r;
  logic [SESSIONS-1:0]           in_use_r;

  logic [SW-1:0]                 sess_idx;
  logic [FW-1:0]                 lo;
  logic [FW-1:0]                 pages;
  logic [dpot_pkg::ADDR_W-1:0]   hi_sum;
  logic [CW-1:0]                 cnt_rdata;
  logic [FW-1:0]                 frame_rdata;
  logic [AW-1:0]                 frame_waddr;
  logic [AW-1:0]                 frame_raddr;

  assign sess_idx    = sess_r[SW-1:0];
  assign lo          = addr_r[dpot_pkg::ADDR_W-1:dpot_pkg::PAGE_SH];
  assign pages       = hi_r - lo;
  assign hi_sum      = sum_r + dpot_pkg::PAGE_MASK;
  assign frame_waddr = base_r + AW'(cnt_r);
  assign frame_raddr = base_r + AW'(idx_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_use_r <= '0;
    end else if (cmd.set_use) begin
      in_use_r[sess_idx] <= 1'b1;
    end else if (cmd.clr_use) begin
      in_use_r[sess_idx] <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_r  <= in_req_type;
      sess_r <= in_session;
      addr_r <= in_address;
      len_r  <= in_length;
    end
    if (cmd.calc_sum) begin
      sum_r <= addr_r + dpot_pkg::ADDR_W'(len_r);
    end
    if (cmd.calc_hi) begin
      hi_r   <= hi_sum[dpot_pkg::ADDR_W-1:dpot_pkg::PAGE_SH];
      cnt_r  <= in_use_r[sess_idx] ? cnt_rdata : '0;
      base_r <= AW'(32'(sess_r) * PAGES_PER_DOMAIN);
    end
    if (cmd.setup) begin
      p_r   <= lo;
      idx_r <= '0;
      rem_r <= CW'(pages);
    end
    if (cmd.grant_step) begin
      p_r   <= p_r + FW'(1);
      cnt_r <= cnt_r + CW'(1);
    end
    if (cmd.hit_step) begin
      p_r   <= p_r + FW'(1);
      rem_r <= rem_r - CW'(1);
      idx_r <= '0;
    end
    if (cmd.miss_step) begin
      idx_r <= idx_r + CW'(1);
    end
  end

  dpot_ram #(
    .WIDTH (FW),
    .DEPTH (DEPTH)
  ) u_frame_ram (
    .clk   (clk),
    .we    (cmd.grant_step),
    .waddr (frame_waddr),
    .wdata (p_r),
    .raddr (frame_raddr),
    .rdata (frame_rdata)
  );

  dpot_ram #(
    .WIDTH (CW),
    .DEPTH (SESSIONS)
  ) u_count_ram (
    .clk   (clk),
    .we    (cmd.cnt_wr),
    .waddr (sess_idx),
    .wdata (cnt_r),
    .raddr (sess_idx),
    .rdata (cnt_rdata)
  );

  always_comb begin
    sts.sid_bad    = (32'(sess_r) >= SESSIONS);
    sts.in_use     = in_use_r[sess_idx];
    sts.empty      = (hi_r <= lo);
    sts.too_many   = (pages > FW'(cnt_r));
    sts.grant_end  = (p_r >= hi_r);
    sts.full       = (cnt_r >= CW'(PAGES_PER_DOMAIN));
    sts.hit        = (frame_rdata == p_r);
    sts.last_page  = (rem_r == CW'(1));
    sts.last_entry = ((CW + 1)'(idx_r) + (CW + 1)'(1) == (CW + 1)'(cnt_r));
    sts.req        = dpot_pkg::req_t'(req_r);
  end

endmodule

### hdl/dpot_ctrl.sv
module dpot_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  output logic           out_valid,
  input  logic           out_ready,
  output logic [1:0]     out_status,
  output dpot_pkg::cmd_t cmd,
  input  dpot_pkg::sts_t sts
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_SUM,
    S_HI,
    S_DECIDE,
    S_GRANT,
    S_CHK_RD,
    S_CHK_CMP,
    S_FIN
  } state_t;

  state_t              state_r, state_nxt;
  dpot_pkg::status_t   st_r, st_nxt;
  logic                out_valid_r, out_valid_nxt;
  dpot_pkg::status_t   out_status_r, out_status_nxt;

  assign in_ready   = (state_r == S_IDLE);
  assign out_valid  = out_valid_r;
  assign out_status = out_status_r;

  always_comb begin
    state_nxt      = state_r;
    st_nxt         = st_r;
    out_valid_nxt  = out_valid_r & ~out_ready;
    out_status_nxt = out_status_r;
    cmd            = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_SUM;
        end
      end
      S_SUM: begin
        cmd.calc_sum = 1'b1;
        state_nxt    = S_HI;
      end
      S_HI: begin
        cmd.calc_hi = 1'b1;
        state_nxt   = S_DECIDE;
      end
      S_DECIDE: begin
        state_nxt = S_FIN;
        if (sts.sid_bad) begin
          st_nxt = dpot_pkg::ST_BADSID;
        end else begin
          unique case (sts.req)
            dpot_pkg::REQ_GRANT: begin
              cmd.set_use = 1'b1;
              cmd.setup   = 1'b1;
              state_nxt   = S_GRANT;
            end
            dpot_pkg::REQ_CHECK: begin
              if (!sts.in_use || (!sts.empty && sts.too_many)) begin
                st_nxt = dpot_pkg::ST_DENY;
              end else if (sts.empty) begin
                st_nxt = dpot_pkg::ST_OK;
              end else begin
                cmd.setup = 1'b1;
                state_nxt = S_CHK_RD;
              end
            end
            dpot_pkg::REQ_REVOKE: begin
              cmd.clr_use = 1'b1;
              st_nxt      = dpot_pkg::ST_OK;
            end
            default: begin
              st_nxt = dpot_pkg::ST_DENY;
            end
          endcase
        end
      end
      S_GRANT: begin
        if (sts.grant_end) begin
          cmd.cnt_wr = 1'b1;
          st_nxt     = dpot_pkg::ST_OK;
          state_nxt  = S_FIN;
        end else if (sts.full) begin
          cmd.cnt_wr = 1'b1;
          st_nxt     = dpot_pkg::ST_FULL;
          state_nxt  = S_FIN;
        end else begin
          cmd.grant_step = 1'b1;
        end
      end
      S_CHK_RD: begin
        state_nxt = S_CHK_CMP;
      end
      S_CHK_CMP: begin
        if (sts.hit) begin
          if (sts.last_page) begin
            st_nxt    = dpot_pkg::ST_OK;
            state_nxt = S_FIN;
          end else begin
            cmd.hit_step = 1'b1;
            state_nxt    = S_CHK_RD;
          end
        end else if (sts.last_entry) begin
          st_nxt    = dpot_pkg::ST_DENY;
          state_nxt = S_FIN;
        end else begin
          cmd.miss_step = 1'b1;
          state_nxt     = S_CHK_RD;
        end
      end
      S_FIN: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = st_r;
          state_nxt      = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      out_valid_r  <= 1'b0;
      st_r         <= dpot_pkg::ST_OK;
      out_status_r <= dpot_pkg::ST_OK;
    end else begin
      state_r      <= state_nxt;
      out_valid_r  <= out_valid_nxt;
      st_r         <= st_nxt;
      out_status_r <= out_status_nxt;
    end
  end

endmodule

### hdl/dma_page_ownership_table_core.sv
// Each accepted request passes S_SUM, S_HI and S_DECIDE; a revoke, an unused request type, an
// invalid session, an empty check or a check rejected at once then goes to S_FIN; a grant
// writes its pages in S_GRANT; a check compares each stored frame in S_CHK_RD and S_CHK_CMP,
// one registered read at a time. One request is in flight at a time: in_ready rises with
// out_valid, and a result still waiting in the output register holds the request in S_FIN.
// Reset clears the controller and the domain in-use bits; the frame and count memories are not.
module dma_page_ownership_table_core #(
  parameter int SESSIONS         = 8,
  parameter int PAGES_PER_DOMAIN = 1024
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_req_type,
  input  logic [7:0]  in_session,
  input  logic [63:0] in_address,
  input  logic [31:0] in_length,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_status
);

  dpot_pkg::cmd_t cmd;
  dpot_pkg::sts_t sts;

  dpot_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_status (out_status),
    .cmd        (cmd),
    .sts        (sts)
  );

  dpot_dp #(
    .SESSIONS         (SESSIONS),
    .PAGES_PER_DOMAIN (PAGES_PER_DOMAIN)
  ) u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_req_type (in_req_type),
    .in_session  (in_session),
    .in_address  (in_address),
    .in_length   (in_length),
    .cmd         (cmd),
    .sts         (sts)
  );

endmodule
